// ===== hdl/mtl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtl_pkg
// shared types and constants of the one-shot timer list
// ----------------------------------------------------------------------------
package mtl_pkg;

   localparam int TIMER_SLOTS_DEF = 10;
   localparam int MAX_RESULTS     = 10;
   localparam int FIRE_W          = $clog2(MAX_RESULTS + 1);

   localparam logic [15:0] EMPTY_PERIOD = 16'hFFFF;
   localparam logic [15:0] RESET_PERIOD = 16'd100;

   // command codes
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_EXPIRE = 1'b1;

   typedef enum logic [1:0] {
      KIND_ADDED = 2'd0,
      KIND_FULL  = 2'd1,
      KIND_FIRED = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_COMPACT,
      ST_NONE
   } state_type;

   // one timer as held in a cell
   typedef struct packed {
      logic [15:0] rem;
      logic [15:0] tag;
      logic        fire;
   } entry_type;

   // broadcast control to every cell
   typedef struct packed {
      logic      shift;
      logic      load;
      entry_type entry;
   } cell_ctl_type;

endpackage

// ===== hdl/mtl_cell.sv =====
// ----------------------------------------------------------------------------
// mtl_cell
// one timer slot of the chain: holds, shifts towards the head, or loads
// ----------------------------------------------------------------------------
module mtl_cell #(
   parameter int IDX_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  mtl_pkg::cell_ctl_type ctl,
   input  logic [IDX_W-1:0]     tail,
   input  mtl_pkg::entry_type   from_next,
   output mtl_pkg::entry_type   q
);
   import mtl_pkg::*;

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift && (MY_INDEX < tail)) begin
         entry_in = from_next;
      end
      // the tail cell takes the broadcast entry
      if (ctl.load && (MY_INDEX == tail)) begin
         entry_in = ctl.entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

// ===== hdl/multiplexed_oneshot_timer_list.sv =====
// ----------------------------------------------------------------------------
// multiplexed_oneshot_timer_list
// ordered list of one-shot timers sharing one hardware period
// ----------------------------------------------------------------------------
// usage
//   req channel: one transfer per command. an add appends a timer (duration,
//   tag); an expire stands for the elapse of the current period.
//   rsp channel: one or more transfers per command, the final one with
//   rsp_last set. every result carries the period and timer count that hold
//   once the whole command is done.
//   an add loads its result into the result register once that is free.
//   an expire rotates the chain twice: a scan pass that subtracts the
//   period, marks fired timers and finds the new minimum, then a
//   compaction pass that drops fired timers and sends their results. both
//   passes take one head cell per cycle; a fired head waits while the
//   receiver stalls. when nothing fires, one nothing-fired result follows.
//   req_ready is high only while idle: one command is in flight at a time.
//   the result register holds a finished result while rsp_ready is low.
//   reset empties the list and sets the period to 100 ms; there is no
//   clearing pass, slot contents are only read below the timer count.
// ----------------------------------------------------------------------------
module multiplexed_oneshot_timer_list #(
   parameter int TIMER_SLOTS = mtl_pkg::TIMER_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_duration_ms,
   input  logic [15:0] req_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_slot,
   output logic [15:0] rsp_fired_tag,
   output logic [15:0] rsp_next_period_ms,
   output logic [3:0]  rsp_active_count,
   output logic        rsp_last
);
   import mtl_pkg::*;

   localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
   localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(TIMER_SLOTS);
   localparam logic [FIRE_W-1:0] MAX_FIRE  = FIRE_W'(MAX_RESULTS);

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [15:0]       period_ff, period_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;      // count at the start of an expire
   logic [CNT_W-1:0]  ring_ff, ring_in;    // live length of the rotating list
   logic [FIRE_W-1:0] nf_ff, nf_in;        // timers marked to fire
   logic [FIRE_W-1:0] left_ff, left_in;    // fire results still to send
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [15:0]       min_ff, min_in;
   logic [15:0]       dur_ff, dur_in;
   logic [15:0]       tag_ff, tag_in;
   kind_type          kind_ff, kind_in;
   logic [3:0]        slot_ff, slot_in;
   logic [15:0]       ftag_ff, ftag_in;
   logic [15:0]       per_ff, per_in;
   logic [3:0]        act_ff, act_in;
   logic              last_ff, last_in;

   // chain
   entry_type         cell_q    [TIMER_SLOTS];
   entry_type         cell_next [TIMER_SLOTS];
   cell_ctl_type      cell_ctl;
   logic [IDX_W-1:0]  cell_tail;

   // head of the chain and per-cycle decisions
   entry_type         head;
   logic [15:0]       sub_rem;
   logic              scan_fire;
   logic              scan_active;
   logic              scan_done;
   logic              comp_active;
   logic              comp_done;
   logic              comp_go;
   logic              out_free;
   logic              req_xfer;
   logic              add_ok;
   logic              add_go;
   logic [15:0]       add_period;
   logic              rsp_load;

   assign head      = cell_q[0];
   assign sub_rem   = (head.rem >= period_ff) ? (head.rem - period_ff) : 16'd0;
   assign scan_fire = (sub_rem == 16'd0) && (nf_ff < MAX_FIRE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign add_ok    = count_ff < SLOTS_CNT;
   assign add_period = ((count_ff == '0) || (dur_ff < period_ff)) ? dur_ff : period_ff;

   assign scan_active = (state_ff == ST_SCAN) && (step_ff < cnt_ff);
   assign scan_done   = (state_ff == ST_SCAN) && (step_ff == cnt_ff);
   assign comp_active = (state_ff == ST_COMPACT) && (step_ff < cnt_ff);
   assign comp_done   = (state_ff == ST_COMPACT) && (step_ff == cnt_ff);
   // a fired head only leaves once its result has somewhere to go
   assign comp_go     = comp_active && (!head.fire || out_free);
   assign add_go      = (state_ff == ST_ADD) && out_free;

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_cmd == CMD_ADD) ? ST_ADD : ST_SCAN;
            end
         end
         ST_ADD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_COMPACT;
            end
         end
         ST_COMPACT: begin
            if (comp_done) begin
               state_in = (nf_ff == '0) ? ST_NONE : ST_IDLE;
            end
         end
         ST_NONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // outputs: chain control and result register load
   // ------------------------------------------------------------------------
   always_comb begin
      req_ready      = 1'b0;
      cell_ctl.shift = 1'b0;
      cell_ctl.load  = 1'b0;
      cell_ctl.entry = head;
      cell_tail      = '0;
      rsp_load       = 1'b0;
      kind_in        = kind_ff;
      slot_in        = slot_ff;
      ftag_in        = ftag_ff;
      per_in         = per_ff;
      act_in         = act_ff;
      last_in        = last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_ADD: begin
            // append at the first free slot
            cell_ctl.load  = add_go && add_ok;
            cell_ctl.entry = '{rem: dur_ff, tag: tag_ff, fire: 1'b0};
            cell_tail      = IDX_W'(count_ff);
            rsp_load       = add_go;
            kind_in        = add_ok ? KIND_ADDED : KIND_FULL;
            slot_in        = add_ok ? 4'(count_ff) : 4'd0;
            ftag_in        = 16'd0;
            per_in         = add_ok ? add_period : period_ff;
            act_in         = add_ok ? 4'(count_ff + CNT_W'(1)) : 4'(count_ff);
            last_in        = 1'b1;
         end
         ST_SCAN: begin
            // rotate once round the list, head re-enters at the tail updated
            cell_ctl.shift = scan_active;
            cell_ctl.load  = scan_active;
            cell_ctl.entry = '{rem: sub_rem, tag: head.tag, fire: scan_fire};
            cell_tail      = IDX_W'(cnt_ff - CNT_W'(1));
         end
         ST_COMPACT: begin
            // kept timers go back to the tail, fired ones leave the ring
            cell_ctl.shift = comp_go;
            cell_ctl.load  = comp_go && !head.fire;
            cell_ctl.entry = head;
            cell_tail      = IDX_W'(ring_ff - CNT_W'(1));
            rsp_load       = comp_active && head.fire && out_free;
            kind_in        = KIND_FIRED;
            slot_in        = 4'(step_ff);
            ftag_in        = head.tag;
            per_in         = period_ff;
            act_in         = 4'(count_ff);
            last_in        = (left_ff == FIRE_W'(1));
         end
         ST_NONE: begin
            rsp_load = out_free;
            kind_in  = KIND_NONE;
            slot_in  = 4'd0;
            ftag_in  = 16'd0;
            per_in   = period_ff;
            act_in   = 4'(count_ff);
            last_in  = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // list bookkeeping
   // ------------------------------------------------------------------------
   always_comb begin
      count_in  = count_ff;
      period_in = period_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      ring_in   = ring_ff;
      nf_in     = nf_ff;
      left_in   = left_ff;
      min_in    = min_ff;
      dur_in    = dur_ff;
      tag_in    = tag_ff;

      if (req_xfer) begin
         dur_in  = req_duration_ms;
         tag_in  = req_tag;
         step_in = '0;
         cnt_in  = count_ff;
         ring_in = count_ff;
         nf_in   = '0;
         min_in  = EMPTY_PERIOD;
      end

      if (add_go && add_ok) begin
         count_in  = count_ff + CNT_W'(1);
         period_in = add_period;
      end

      if (scan_active) begin
         step_in = step_ff + CNT_W'(1);
         if (scan_fire) begin
            nf_in = nf_ff + FIRE_W'(1);
         end else if (sub_rem < min_in) begin
            min_in = sub_rem;
         end
      end

      // period and count are final once the scan is through
      if (scan_done) begin
         period_in = min_ff;
         count_in  = cnt_ff - CNT_W'(nf_ff);
         step_in   = '0;
         left_in   = nf_ff;
      end

      if (comp_go) begin
         step_in = step_ff + CNT_W'(1);
         if (head.fire) begin
            ring_in = ring_ff - CNT_W'(1);
            left_in = left_ff - FIRE_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         period_ff    <= RESET_PERIOD;
         step_ff      <= '0;
         cnt_ff       <= '0;
         ring_ff      <= '0;
         nf_ff        <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         period_ff    <= period_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         ring_ff      <= ring_in;
         nf_ff        <= nf_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
      dur_ff <= dur_in;
      tag_ff <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         kind_ff <= kind_in;
         slot_ff <= slot_in;
         ftag_ff <= ftag_in;
         per_ff  <= per_in;
         act_ff  <= act_in;
         last_ff <= last_in;
      end
   end

   // ------------------------------------------------------------------------
   // chain of timer cells, cell 0 is the head
   // ------------------------------------------------------------------------
   for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
      if (g == TIMER_SLOTS - 1) begin : g_end
         assign cell_next[g] = '0;
      end else begin : g_mid
         assign cell_next[g] = cell_q[g + 1];
      end

      mtl_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .tail      (cell_tail),
         .from_next (cell_next[g]),
         .q         (cell_q[g])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_slot           = slot_ff;
   assign rsp_fired_tag      = ftag_ff;
   assign rsp_next_period_ms = per_ff;
   assign rsp_active_count   = act_ff;
   assign rsp_last           = last_ff;

endmodule

// ===== hdl/mtl_checker.sv =====
// ----------------------------------------------------------------------------
// mtl_checker
// port-level checks of the one-shot timer list
// ----------------------------------------------------------------------------
module mtl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [3:0]  rsp_slot,
   input logic [15:0] rsp_fired_tag,
   input logic [3:0]  rsp_active_count,
   input logic        rsp_last
);
   import mtl_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_slot)
         && $stable(rsp_fired_tag) && $stable(rsp_last))
      else $error("stalled result changed");

   // one command at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer taken while busy");

   // an add lands in the slot just below the new count
   a_add_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ADDED) |->
         (rsp_active_count == 4'(rsp_slot + 4'd1)) && rsp_last)
      else $error("added slot does not match count");

   // single-result kinds carry no slot or tag
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == KIND_FULL) || (rsp_kind == KIND_NONE)) |->
         rsp_last && (rsp_slot == 4'd0) && (rsp_fired_tag == 16'd0))
      else $error("bad full or nothing-fired result");

endmodule

bind multiplexed_oneshot_timer_list mtl_checker u_mtl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_slot         (rsp_slot),
   .rsp_fired_tag    (rsp_fired_tag),
   .rsp_active_count (rsp_active_count),
   .rsp_last         (rsp_last)
);

// ===== verif/multiplexed_oneshot_timer_list_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiplexed_oneshot_timer_list_tb
// self-checking bench for the one-shot timer list
// ----------------------------------------------------------------------------
// commands go in on the req channel. the bench keeps its own copy of the
// timer list, and that copy works out the results of each accepted command.
// a checker compares every rsp transfer, field by field, with the oldest
// result still due. directed tests come first: an expire on the empty list,
// extreme durations and tags, a partial expiry, and a full list. a random run
// follows. both sides idle at random, with some stretches that have no
// idling at all.
// ----------------------------------------------------------------------------
module multiplexed_oneshot_timer_list_tb;
   import mtl_pkg::*;

   localparam int SLOTS         = TIMER_SLOTS_DEF;
   localparam int MAX_IDLE      = 17;
   localparam int RANDOM_ITEMS  = 150;
   // bound on a stretch with no transfer before the watchdog ends the run
   localparam int QUIET_LIMIT   = 2000;
   // settle time after the drain, scaled with the number of slots
   localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

   typedef struct {
      kind_type    kind;
      logic [3:0]  slot;
      logic [15:0] fired_tag;
      logic [15:0] next_period_ms;
      logic [3:0]  active_count;
      logic        last;
   } timer_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [15:0] req_duration_ms;
   logic [15:0] req_tag;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_slot;
   logic [15:0] rsp_fired_tag;
   logic [15:0] rsp_next_period_ms;
   logic [3:0]  rsp_active_count;
   logic        rsp_last;

   // bench copy of the timer list
   logic [15:0] list_rem_ms [SLOTS];
   logic [15:0] list_tags   [SLOTS];
   int          list_count;
   logic [15:0] list_period_ms;

   // results worked out but not yet seen on the rsp channel
   timer_result_type due_results [$];

   int failures = 0;
   // set while both sides run with no idling
   bit bursting = 1'b0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   multiplexed_oneshot_timer_list i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_duration_ms    (req_duration_ms),
      .req_tag            (req_tag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_slot           (rsp_slot),
      .rsp_fired_tag      (rsp_fired_tag),
      .rsp_next_period_ms (rsp_next_period_ms),
      .rsp_active_count   (rsp_active_count),
      .rsp_last           (rsp_last)
   );

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   function automatic int idle_cycles();
      return bursting ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   function automatic timer_result_type make_result(kind_type kind, int slot,
                                                    logic [15:0] tagv);
      timer_result_type r;
      r.kind           = kind;
      r.slot           = slot[3:0];
      r.fired_tag      = tagv;
      r.next_period_ms = '0;
      r.active_count   = '0;
      r.last           = 1'b0;
      return r;
   endfunction

   // updates the list copy for one command and queues the results it causes
   function automatic void apply_command(logic cmd, logic [15:0] duration,
                                         logic [15:0] tagv);
      timer_result_type batch [$];
      logic [15:0]      elapsed;
      int               kept;
      int               i;
      bit               touched;
      touched = 1'b1;
      if (cmd == CMD_ADD) begin
         if (list_count >= SLOTS) begin
            // full list: the add is dropped, list and period stay as they were
            batch.push_back(make_result(KIND_FULL, 0, '0));
            touched = 1'b0;
         end else begin
            list_rem_ms[list_count] = duration;
            list_tags[list_count]   = tagv;
            batch.push_back(make_result(KIND_ADDED, list_count, '0));
            list_count++;
         end
      end else begin
         // subtract the current period, floor at zero, fire and compact in
         // one walk; kept never runs ahead of i
         elapsed = list_period_ms;
         kept    = 0;
         for (i = 0; i < list_count; i++) begin
            list_rem_ms[i] = (list_rem_ms[i] >= elapsed) ? list_rem_ms[i] - elapsed
                                                         : 16'd0;
            if (list_rem_ms[i] == 16'd0 && batch.size() < MAX_RESULTS) begin
               batch.push_back(make_result(KIND_FIRED, i, list_tags[i]));
            end else begin
               list_rem_ms[kept] = list_rem_ms[i];
               list_tags[kept]   = list_tags[i];
               kept++;
            end
         end
         list_count = kept;
      end
      if (touched) begin
         list_period_ms = EMPTY_PERIOD;
         for (i = 0; i < list_count; i++) begin
            if (list_rem_ms[i] < list_period_ms) list_period_ms = list_rem_ms[i];
         end
      end
      if (cmd == CMD_EXPIRE && batch.size() == 0) begin
         batch.push_back(make_result(KIND_NONE, 0, '0));
      end
      // every result carries the state after the whole command
      foreach (batch[k]) begin
         batch[k].next_period_ms = list_period_ms;
         batch[k].active_count   = list_count[3:0];
         batch[k].last           = (k == batch.size() - 1);
         due_results.push_back(batch[k]);
      end
   endfunction

   // ------------------------------------------------------------------------
   // req side: called and left at a falling edge, so valid is never lowered
   // and raised in the same step
   // ------------------------------------------------------------------------

   task automatic send_command(logic cmd, logic [15:0] duration, logic [15:0] tagv);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_duration_ms <= duration;
      req_tag         <= tagv;
      do @(posedge clock); while (req_ready !== 1'b1);
      apply_command(cmd, duration, tagv);
      @(negedge clock);
   endtask

   // sender holds off until every due result has come back
   task automatic wait_list_quiet();
      req_valid <= 1'b0;
      do @(negedge clock); while (due_results.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // rsp side: a fresh stall is drawn after every result transfer
   // ------------------------------------------------------------------------

   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      do @(negedge clock); while (reset !== 1'b0);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // checker
   // ------------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      timer_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (due_results.size() == 0) begin
            $error("rsp transfer with no result due: kind %0d slot %0d",
                   rsp_kind, rsp_slot);
            failures++;
         end else begin
            want = due_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("rsp_kind: expected %0d, actual %0d", want.kind, rsp_kind);
               failures++;
            end
            if (rsp_slot !== want.slot) begin
               $error("rsp_slot: expected %0d, actual %0d", want.slot, rsp_slot);
               failures++;
            end
            if (rsp_fired_tag !== want.fired_tag) begin
               $error("rsp_fired_tag: expected %0h, actual %0h",
                      want.fired_tag, rsp_fired_tag);
               failures++;
            end
            if (rsp_next_period_ms !== want.next_period_ms) begin
               $error("rsp_next_period_ms: expected %0d, actual %0d",
                      want.next_period_ms, rsp_next_period_ms);
               failures++;
            end
            if (rsp_active_count !== want.active_count) begin
               $error("rsp_active_count: expected %0d, actual %0d",
                      want.active_count, rsp_active_count);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %0d, actual %0d", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // ends the run after too long without a transfer on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("** multiplexed_oneshot_timer_list: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // expire straight after reset: nothing fires, period goes to the empty value
   task automatic test_empty_expire();
      send_command(CMD_EXPIRE, 16'hFFFF, 16'hFFFF);
   endtask

   // longest and zero duration, lowest and highest tag; a zero timer fires
   // on the next expire with nothing subtracted
   task automatic test_zero_and_max();
      send_command(CMD_ADD, 16'hFFFF, 16'h0000);
      send_command(CMD_ADD, 16'h0000, 16'hFFFF);
      send_command(CMD_EXPIRE, 16'h0000, 16'h0000);
      send_command(CMD_EXPIRE, 16'h0000, 16'h0000);
   endtask

   // the shorter timer fires, the longer one keeps what is left
   task automatic test_partial_expiry();
      send_command(CMD_ADD, 16'd300, 16'h1234);
      send_command(CMD_ADD, 16'd50, 16'hABCD);
      send_command(CMD_EXPIRE, 16'h5555, 16'hAAAA);
      send_command(CMD_EXPIRE, 16'hAAAA, 16'h5555);
   endtask

   // fill every slot, add once more onto the full list, then fire them all
   // in one expire, the most results one command can give
   task automatic test_full_list();
      int i;
      for (i = 0; i < SLOTS; i++) begin
         send_command(CMD_ADD, 16'd7, 16'h8000 | 16'(i));
      end
      send_command(CMD_ADD, 16'd1, 16'h7FFF);
      send_command(CMD_EXPIRE, 16'h0000, 16'h0000);
      send_command(CMD_EXPIRE, 16'h0000, 16'h0000);
   endtask

   // random adds and expires; adds lean towards durations that collide with
   // timers already in the list so that several fire together
   task automatic test_random();
      logic        cmd;
      logic [15:0] duration;
      int          add_odds;
      int          n;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         bursting = ((n / 30) % 3 == 1);
         if (n % 50 == 40) wait_list_quiet();
         add_odds = (list_count >= SLOTS) ? 30 : ((list_count < 3) ? 75 : 55);
         cmd = ($urandom_range(0, 99) < add_odds) ? CMD_ADD : CMD_EXPIRE;
         case ($urandom_range(0, 7))
            0:       duration = 16'h0000;
            1:       duration = 16'hFFFF;
            2, 3:    duration = 16'($urandom_range(1, 40));
            4:       duration = (list_count > 0)
                                ? list_rem_ms[$urandom_range(0, list_count - 1)]
                                : 16'($urandom_range(0, 65535));
            default: duration = 16'($urandom_range(0, 65535));
         endcase
         send_command(cmd, duration, 16'($urandom_range(0, 65535)));
      end
      bursting = 1'b0;
   endtask

   initial begin : run
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_ADD;
      req_duration_ms = '0;
      req_tag         = '0;
      list_count      = 0;
      list_period_ms  = RESET_PERIOD;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_expire();
      test_zero_and_max();
      test_partial_expiry();
      test_full_list();
      test_random();

      // drain, then leave room for any stray result
      wait_list_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && due_results.size() == 0) begin
         $display("** multiplexed_oneshot_timer_list: PASSED **");
      end else begin
         $display("** multiplexed_oneshot_timer_list: FAILED **");
      end
      $finish;
   end

endmodule
